// ===== rtl/msr_pkg.sv =====
// shared constants and types for the minimal string rotation block
// no dependencies
`timescale 1ns / 1ps

package msr_pkg;

  // default and largest supported string length
  localparam int unsigned MAX_LEN_DEF = 64;

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned START_W = 6;

  // outcome of one byte comparison
  typedef struct packed {
    logic differ;  // bytes are not equal
    logic lt;      // first byte below second
  } cmp_res_t;

endpackage

// ===== rtl/min_string_rotation_unit.sv =====
// sequence: bytes are stored while in S_LOAD; after the last byte the search steps
//   through S_CRD and S_CCMP per byte pair, then emission through S_ERD and S_EOUT
// throughput: one string per load + search + emission; the block is busy meanwhile
// rate is set by the single shared byte comparator and the registered memory reads
// reset: synchronous, active low; clears control state and byte count, memory
//   contents stay undefined
// top level of the minimal string rotation block
// depends on msr_pkg, msr_store, msr_cmp
`timescale 1ns / 1ps

module min_string_rotation_unit #(
  parameter int unsigned MAX_LEN = msr_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [msr_pkg::CHAR_W-1:0]    in_char_in,
  input  logic                          in_is_last,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msr_pkg::CHAR_W-1:0]    out_char_out,
  output logic [msr_pkg::START_W-1:0]   out_rotation_start,
  output logic                          out_end_of_run
);

  localparam int unsigned AW = $clog2(MAX_LEN);      // memory index width
  localparam int unsigned CW = $clog2(MAX_LEN + 1);  // count width, holds MAX_LEN

  // sequencer states
  typedef enum logic [2:0] {
    S_LOAD,   // taking bytes of the string
    S_CRD,    // compare: memory read in flight
    S_CCMP,   // compare: evaluate one byte pair
    S_ERD,    // emit: memory read in flight
    S_EOUT    // emit: move byte into output register
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;     // bytes stored, string length later
  logic [AW-1:0]              cand_r, cand_nxt;   // candidate start index
  logic [AW-1:0]              best_r, best_nxt;   // best start so far
  logic [AW-1:0]              ia_r, ia_nxt;       // walk index of candidate (or emit)
  logic [AW-1:0]              ib_r, ib_nxt;       // walk index of best
  logic [CW-1:0]              k_r, k_nxt;         // bytes compared or emitted

  logic                       out_valid_r, out_valid_nxt;
  logic [msr_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [AW-1:0]              out_start_r, out_start_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       mem_we;
  logic [msr_pkg::CHAR_W-1:0] rd_a, rd_b;
  msr_pkg::cmp_res_t          cmp;

  // helper values; the index sums are widened to count width
  logic                       in_acc;
  logic                       has_room;
  logic [CW-1:0]              len_w;
  logic [CW-1:0]              k_inc;
  logic [CW-1:0]              cand_inc;
  logic [CW-1:0]              ia_inc;
  logic [CW-1:0]              ib_inc;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid & in_ready;
  assign has_room = (cnt_r < CW'(MAX_LEN));
  assign mem_we   = in_acc & has_room;
  // length including this byte; surplus bytes are dropped
  assign len_w    = has_room ? (cnt_r + CW'(1)) : cnt_r;
  assign k_inc    = k_r + CW'(1);
  assign cand_inc = CW'(cand_r) + CW'(1);
  assign ia_inc   = CW'(ia_r) + CW'(1);
  assign ib_inc   = CW'(ib_r) + CW'(1);

  msr_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   (in_char_in),
    .raddr_a (ia_r),
    .raddr_b (ib_r),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  msr_cmp u_cmp (
    .byte_a (rd_a),
    .byte_b (rd_b),
    .res    (cmp)
  );

  always_comb begin
    logic          cand_wins;
    logic          cand_done;
    logic [AW-1:0] best_new;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cand_nxt      = cand_r;
    best_nxt      = best_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    k_nxt         = k_r;
    out_char_nxt  = out_char_r;
    out_start_nxt = out_start_r;
    out_last_nxt  = out_last_r;
    // output register drains when taken
    out_valid_nxt = out_valid_r & ~out_ready;

    cand_wins = 1'b0;
    cand_done = 1'b0;
    best_new  = best_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cnt_nxt = len_w;
          if (in_is_last) begin
            best_nxt = '0;
            k_nxt    = '0;
            if (len_w == CW'(1)) begin
              // single byte: nothing to search
              ia_nxt    = '0;
              state_nxt = S_ERD;
            end else begin
              cand_nxt  = AW'(1);
              ia_nxt    = AW'(1);
              ib_nxt    = '0;
              state_nxt = S_CRD;
            end
          end
        end
      end

      S_CRD: begin
        state_nxt = S_CCMP;
      end

      S_CCMP: begin
        if (cmp.differ) begin
          cand_done = 1'b1;
          cand_wins = cmp.lt;
        end else if (k_inc == cnt_r) begin
          // whole rotations equal: larger start wins the tie
          cand_done = 1'b1;
          cand_wins = 1'b1;
        end else begin
          k_nxt     = k_inc;
          ia_nxt    = (ia_inc >= cnt_r) ? '0 : ia_inc[AW-1:0];
          ib_nxt    = (ib_inc >= cnt_r) ? '0 : ib_inc[AW-1:0];
          state_nxt = S_CRD;
        end

        if (cand_done) begin
          best_new = cand_wins ? cand_r : best_r;
          best_nxt = best_new;
          k_nxt    = '0;
          if (cand_inc == cnt_r) begin
            // search over, emit from the best start
            ia_nxt    = best_new;
            state_nxt = S_ERD;
          end else begin
            cand_nxt  = cand_inc[AW-1:0];
            ia_nxt    = cand_inc[AW-1:0];
            ib_nxt    = best_new;
            state_nxt = S_CRD;
          end
        end
      end

      S_ERD: begin
        state_nxt = S_EOUT;
      end

      S_EOUT: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_a;
          out_start_nxt = best_r;
          out_last_nxt  = (k_inc == cnt_r);
          if (k_inc == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            ia_nxt    = (ia_inc >= cnt_r) ? '0 : ia_inc[AW-1:0];
            state_nxt = S_ERD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    best_r      <= best_nxt;
    ia_r        <= ia_nxt;
    ib_r        <= ib_nxt;
    k_r         <= k_nxt;
    out_char_r  <= out_char_nxt;
    out_start_r <= out_start_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_char_out       = out_char_r;
  assign out_rotation_start = msr_pkg::START_W'(out_start_r);
  assign out_end_of_run     = out_last_r;

endmodule

// ===== rtl/msr_store.sv =====
// character memory: one write port, two registered read ports
// depends on msr_pkg
`timescale 1ns / 1ps

module msr_store #(
  parameter int unsigned DEPTH = msr_pkg::MAX_LEN_DEF,
  parameter int unsigned AW    = $clog2(msr_pkg::MAX_LEN_DEF)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [msr_pkg::CHAR_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [msr_pkg::CHAR_W-1:0]  rdata_a,
  output logic [msr_pkg::CHAR_W-1:0]  rdata_b
);

  logic [msr_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/msr_cmp.sv =====
// shared byte comparator used for every step of the rotation search
// depends on msr_pkg
`timescale 1ns / 1ps

module msr_cmp (
  input  logic [msr_pkg::CHAR_W-1:0] byte_a,
  input  logic [msr_pkg::CHAR_W-1:0] byte_b,
  output msr_pkg::cmp_res_t          res
);

  // unsigned compare of the two bytes
  assign res.differ = (byte_a != byte_b);
  assign res.lt     = (byte_a < byte_b);

endmodule
